@@ rtl/ivsu_pkg.sv @@
`timescale 1ns / 1ps
package ivsu_pkg;

  // Request codes
  localparam logic [1:0] REQ_INS0  = 2'd0;
  localparam logic [1:0] REQ_INS1  = 2'd1;
  localparam logic [1:0] REQ_ISECT = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_INTERVAL = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_INVALID  = 3'd4;

  // Queue control for one row of cells
  typedef struct packed {
    logic pop;
    logic push;
  } ivsu_ctl_t;

endpackage

@@ rtl/ivsu_cell.sv @@
`timescale 1ns / 1ps
module ivsu_cell #(
  parameter int CB = 21
) (
  input  logic          clk,
  input  logic          shift,
  input  logic          wr_en,
  input  logic [CB-1:0] nb_st,
  input  logic [CB-1:0] nb_ed,
  input  logic [CB-1:0] wd_st,
  input  logic [CB-1:0] wd_ed,
  input  logic [CB-1:0] q_lo,
  input  logic [CB-1:0] q_hi,
  output logic [CB-1:0] st,
  output logic [CB-1:0] ed,
  output logic          touch
);

  logic [CB-1:0] st_r, st_nxt;
  logic [CB-1:0] ed_r, ed_nxt;

  // Take new data, take the right neighbor, or hold
  always_comb begin
    if (wr_en) begin
      st_nxt = wd_st;
      ed_nxt = wd_ed;
    end else if (shift) begin
      st_nxt = nb_st;
      ed_nxt = nb_ed;
    end else begin
      st_nxt = st_r;
      ed_nxt = ed_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    ed_r <= ed_nxt;
  end

  // Overlap or touch against the query interval
  assign touch = (st_r <= q_hi) && (ed_r >= q_lo);
  assign st    = st_r;
  assign ed    = ed_r;

endmodule

@@ rtl/ivsu_row.sv @@
`timescale 1ns / 1ps
module ivsu_row #(
  parameter int DEPTH = 16,
  parameter int CB    = 21
) (
  input  logic                       clk,
  input  ivsu_pkg::ivsu_ctl_t        ctl,
  input  logic [$clog2(DEPTH+1)-1:0] cnt,
  input  logic [CB-1:0]              wd_st,
  input  logic [CB-1:0]              wd_ed,
  input  logic [CB-1:0]              q_lo,
  input  logic [CB-1:0]              q_hi,
  output logic [CB-1:0]              hd_st,
  output logic [CB-1:0]              hd_ed,
  output logic                       any_hit
);
  import ivsu_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CB-1:0]    st_a [DEPTH];
  logic [CB-1:0]    ed_a [DEPTH];
  logic [DEPTH-1:0] touch;
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] wr_en;

  // Chain of cells: a pop moves every entry one place toward the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NB = (i == DEPTH - 1) ? i : i + 1;

    // Push lands at the tail, one place lower when the row pops too
    assign wr_en[i] = ctl.push &&
                      (ctl.pop ? (cnt == CW'(i + 1)) : (cnt == CW'(i)));
    assign hit[i]   = touch[i] && (CW'(i) < cnt);

    ivsu_cell #(.CB(CB)) u_cell (
      .clk   (clk),
      .shift (ctl.pop),
      .wr_en (wr_en[i]),
      .nb_st (st_a[NB]),
      .nb_ed (ed_a[NB]),
      .wd_st (wd_st),
      .wd_ed (wd_ed),
      .q_lo  (q_lo),
      .q_hi  (q_hi),
      .st    (st_a[i]),
      .ed    (ed_a[i]),
      .touch (touch[i])
    );
  end

  assign hd_st   = st_a[0];
  assign hd_ed   = ed_a[0];
  assign any_hit = |hit;

endmodule

@@ rtl/interval_set_union_intersect.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                  | Direction | Handshake
// ---------+----------------------------------------+-----------+----------------------
// input    | in_req_type, in_lo, in_hi              | in        | start & !busy
// result   | out_kind, out_lo, out_hi, out_last     | out       | out_valid, one cycle
//
// Each set is a row of SET_DEPTH cells run as a queue; a step pops the head
// and/or pushes at the tail. An insert runs a check step, then a step per stored
// entry plus placement. An intersect runs one merge step per popped entry (at
// most 2*SET_DEPTH - 1), one closing step and the output register. Rejected
// inserts finish after the check step. Results go out through a register and
// cannot be held off. Reset (rst_n low, synchronous) empties both sets.
module interval_set_union_intersect #(
  parameter int SET_DEPTH  = 16,
  parameter int COORD_BITS = 21
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_req_type,
  input  logic [COORD_BITS-1:0] in_lo,
  input  logic [COORD_BITS-1:0] in_hi,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [COORD_BITS-1:0] out_lo,
  output logic [COORD_BITS-1:0] out_hi,
  output logic                  out_last
);
  import ivsu_pkg::*;

  localparam int CW = $clog2(SET_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_INS, S_ISECT} state_t;

  state_t                state_r, state_nxt;
  logic                  sel_r, sel_nxt;
  logic [COORD_BITS-1:0] n_lo_r, n_lo_nxt, n_hi_r, n_hi_nxt;
  logic                  placed_r, placed_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [CW-1:0]         cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [COORD_BITS-1:0] pend_lo_r, pend_lo_nxt, pend_hi_r, pend_hi_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_kind_r, out_kind_nxt;
  logic [COORD_BITS-1:0] out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  logic                  out_last_r, out_last_nxt;

  ivsu_ctl_t             ctl0, ctl1, ins_ctl;
  logic [COORD_BITS-1:0] wd_st, wd_ed;
  logic [COORD_BITS-1:0] hd0_st, hd0_ed, hd1_st, hd1_ed;
  logic                  hit0, hit1;
  logic [COORD_BITS-1:0] h_st, h_ed, x_st, x_ed;
  logic [CW-1:0]         cnt_sel, cnt_sel_nxt;
  logic                  hit_sel;

  ivsu_row #(.DEPTH(SET_DEPTH), .CB(COORD_BITS)) u_row0 (
    .clk(clk), .ctl(ctl0), .cnt(cnt0_r), .wd_st(wd_st), .wd_ed(wd_ed),
    .q_lo(n_lo_r), .q_hi(n_hi_r), .hd_st(hd0_st), .hd_ed(hd0_ed),
    .any_hit(hit0)
  );

  ivsu_row #(.DEPTH(SET_DEPTH), .CB(COORD_BITS)) u_row1 (
    .clk(clk), .ctl(ctl1), .cnt(cnt1_r), .wd_st(wd_st), .wd_ed(wd_ed),
    .q_lo(n_lo_r), .q_hi(n_hi_r), .hd_st(hd1_st), .hd_ed(hd1_ed),
    .any_hit(hit1)
  );

  // Selected set for inserts
  assign h_st    = sel_r ? hd1_st : hd0_st;
  assign h_ed    = sel_r ? hd1_ed : hd0_ed;
  assign cnt_sel = sel_r ? cnt1_r : cnt0_r;
  assign hit_sel = sel_r ? hit1 : hit0;

  // Pair overlap of the two heads
  assign x_st = (hd0_st > hd1_st) ? hd0_st : hd1_st;
  assign x_ed = (hd0_ed < hd1_ed) ? hd0_ed : hd1_ed;

  assign cnt_sel_nxt = cnt_sel + CW'(ins_ctl.push) - CW'(ins_ctl.pop);

  // Sequence inserts and intersects
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    n_lo_nxt      = n_lo_r;
    n_hi_nxt      = n_hi_r;
    placed_nxt    = placed_r;
    rem_nxt       = rem_r;
    cnt0_nxt      = cnt0_r;
    cnt1_nxt      = cnt1_r;
    pend_v_nxt    = pend_v_r;
    pend_lo_nxt   = pend_lo_r;
    pend_hi_nxt   = pend_hi_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_lo_nxt    = out_lo_r;
    out_hi_nxt    = out_hi_r;
    out_last_nxt  = out_last_r;
    ins_ctl       = '0;
    ctl0          = '0;
    ctl1          = '0;
    wd_st         = n_lo_r;
    wd_ed         = n_hi_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req_type == REQ_INS0 || in_req_type == REQ_INS1) begin
            sel_nxt   = in_req_type[0];
            n_lo_nxt  = in_lo;
            n_hi_nxt  = in_hi;
            state_nxt = S_CHECK;
          end else if (in_req_type == REQ_ISECT) begin
            pend_v_nxt = 1'b0;
            state_nxt  = S_ISECT;
          end
        end
      end

      S_CHECK: begin
        out_lo_nxt   = '0;
        out_hi_nxt   = '0;
        out_last_nxt = 1'b1;
        priority if (n_lo_r >= n_hi_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_INVALID;
          state_nxt     = S_IDLE;
        end else if (cnt_sel == CW'(SET_DEPTH) && !hit_sel) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FULL;
          state_nxt     = S_IDLE;
        end else begin
          rem_nxt    = cnt_sel;
          placed_nxt = 1'b0;
          state_nxt  = S_INS;
        end
      end

      S_INS: begin
        if (rem_r != '0) begin
          priority if (placed_r) begin
            ins_ctl = '{pop: 1'b1, push: 1'b1};
            wd_st   = h_st;
            wd_ed   = h_ed;
          end else if (h_ed < n_lo_r) begin
            ins_ctl = '{pop: 1'b1, push: 1'b1};
            wd_st   = h_st;
            wd_ed   = h_ed;
          end else if (h_st <= n_hi_r) begin
            // Absorb the touching entry into the new interval
            ins_ctl  = '{pop: 1'b1, push: 1'b0};
            n_lo_nxt = (h_st < n_lo_r) ? h_st : n_lo_r;
            n_hi_nxt = (h_ed > n_hi_r) ? h_ed : n_hi_r;
          end else begin
            // Place the new interval ahead of this entry
            ins_ctl    = '{pop: 1'b0, push: 1'b1};
            placed_nxt = 1'b1;
          end
          rem_nxt = rem_r - CW'(ins_ctl.pop);
        end else begin
          ins_ctl       = '{pop: 1'b0, push: !placed_r};
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_INSERTED;
          out_lo_nxt    = '0;
          out_hi_nxt    = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
        if (sel_r) begin
          ctl1     = ins_ctl;
          cnt1_nxt = cnt_sel_nxt;
        end else begin
          ctl0     = ins_ctl;
          cnt0_nxt = cnt_sel_nxt;
        end
      end

      S_ISECT: begin
        if (cnt0_r != '0 && cnt1_r != '0) begin
          if (x_st < x_ed) begin
            // Release the held overlap now that another follows
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_INTERVAL;
              out_lo_nxt    = pend_lo_r;
              out_hi_nxt    = pend_hi_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_lo_nxt = x_st;
            pend_hi_nxt = x_ed;
          end
          if (hd0_ed < hd1_ed) begin
            ctl0.pop = 1'b1;
            cnt0_nxt = cnt0_r - CW'(1);
          end else begin
            ctl1.pop = 1'b1;
            cnt1_nxt = cnt1_r - CW'(1);
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (pend_v_r) begin
            out_kind_nxt = KIND_INTERVAL;
            out_lo_nxt   = pend_lo_r;
            out_hi_nxt   = pend_hi_r;
          end else begin
            out_kind_nxt = KIND_EMPTY;
            out_lo_nxt   = '0;
            out_hi_nxt   = '0;
          end
          pend_v_nxt = 1'b0;
          cnt0_nxt   = '0;
          cnt1_nxt   = '0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt0_r      <= '0;
      cnt1_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      placed_r    <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt0_r      <= cnt0_nxt;
      cnt1_r      <= cnt1_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      placed_r    <= placed_nxt;
      rem_r       <= rem_nxt;
    end
    sel_r      <= sel_nxt;
    n_lo_r     <= n_lo_nxt;
    n_hi_r     <= n_hi_nxt;
    pend_lo_r  <= pend_lo_nxt;
    pend_hi_r  <= pend_hi_nxt;
    out_kind_r <= out_kind_nxt;
    out_lo_r   <= out_lo_nxt;
    out_hi_r   <= out_hi_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_lo    = out_lo_r;
  assign out_hi    = out_hi_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt0_r <= CW'(SET_DEPTH) && cnt1_r <= CW'(SET_DEPTH))
    else $error("set count above depth");

  a_rem_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> rem_r <= cnt_sel)
    else $error("unscanned entries exceed queue occupancy");

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE))
    else $error("result without work in progress");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("held overlap left over after intersect");
`endif

endmodule
